/* hw/rtl/tcli_pkg.sv */
package tcli_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  localparam logic OP_KEY     = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [2:0] EXT_ENTER     = 3'd1;
  localparam logic [2:0] EXT_BACKSPACE = 3'd2;
  localparam logic [2:0] EXT_UP        = 3'd3;
  localparam logic [2:0] EXT_DOWN      = 3'd4;
  localparam logic [2:0] EXT_FUNCTION  = 3'd5;

  localparam logic [1:0] SCROLL_NONE = 2'd0;
  localparam logic [1:0] SCROLL_UP   = 2'd1;
  localparam logic [1:0] SCROLL_DOWN = 2'd2;

  localparam logic [3:0] LAST_CONSOLE = 4'd11;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_REQUEST,
    CMD_CHAR,
    CMD_SCROLL,
    CMD_CONSOLE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  ch;
    logic [15:0] req;
    logic [1:0]  scroll;
    logic [3:0]  console;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

/* hw/rtl/tcli_front.sv */
module tcli_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [7:0]        in_key_char,
  input  logic              in_is_extended,
  input  logic [2:0]        in_ext_key,
  input  logic [3:0]        in_function_index,
  input  logic              in_shift_held,
  input  logic [15:0]       in_request_count,
  input  logic              queue_full,
  output logic              push,
  output tcli_pkg::cmd_t    push_cmd
);

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_cmd         = '0;
    push_cmd.kind    = tcli_pkg::CMD_NONE;
    push_cmd.req     = in_request_count;
    push_cmd.ch      = in_key_char;
    push_cmd.scroll  = tcli_pkg::SCROLL_NONE;
    push_cmd.console = in_function_index;
    if (in_operation == tcli_pkg::OP_REQUEST) begin
      push_cmd.kind = tcli_pkg::CMD_REQUEST;
    end else if (!in_is_extended) begin
      push_cmd.kind = tcli_pkg::CMD_CHAR;
    end else begin
      unique case (in_ext_key)
        tcli_pkg::EXT_ENTER: begin
          push_cmd.kind = tcli_pkg::CMD_CHAR;
          push_cmd.ch   = tcli_pkg::CH_NEWLINE;
        end
        tcli_pkg::EXT_BACKSPACE: begin
          push_cmd.kind = tcli_pkg::CMD_CHAR;
          push_cmd.ch   = tcli_pkg::CH_BACKSPACE;
        end
        tcli_pkg::EXT_UP: begin
          if (in_shift_held) begin
            push_cmd.kind   = tcli_pkg::CMD_SCROLL;
            push_cmd.scroll = tcli_pkg::SCROLL_UP;
          end
        end
        tcli_pkg::EXT_DOWN: begin
          if (in_shift_held) begin
            push_cmd.kind   = tcli_pkg::CMD_SCROLL;
            push_cmd.scroll = tcli_pkg::SCROLL_DOWN;
          end
        end
        tcli_pkg::EXT_FUNCTION: begin
          if (in_shift_held && in_function_index <= tcli_pkg::LAST_CONSOLE) begin
            push_cmd.kind = tcli_pkg::CMD_CONSOLE;
          end
        end
        default: push_cmd.kind = tcli_pkg::CMD_NONE;
      endcase
    end
  end

endmodule

/* hw/rtl/tcli_queue.sv */
module tcli_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  tcli_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output tcli_pkg::cmd_t          head_cmd,
  output tcli_pkg::queue_status_t status
);

  localparam int DEPTH = tcli_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcli_pkg::cmd_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign head_cmd     = slot_r[rd_ptr_r];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/tcli_back.sv */
module tcli_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tcli_pkg::cmd_t          head_cmd,
  input  tcli_pkg::queue_status_t status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_echo_valid,
  output logic [7:0]              out_echo_char,
  output logic                    out_extra_newline,
  output logic                    out_store_valid,
  output logic [7:0]              out_store_char,
  output logic [15:0]             out_store_index,
  output logic                    out_done_valid,
  output logic [15:0]             out_done_count,
  output logic                    out_request_ack,
  output logic [1:0]              out_scroll_dir,
  output logic                    out_console_select_valid,
  output logic [3:0]              out_console_index
);

  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] xfer_r, xfer_nxt;
  logic [COUNT_WIDTH+15:0] req_wide;
  logic [COUNT_WIDTH+15:0] xfer_wide;
  logic [COUNT_WIDTH+15:0] xfer_nxt_wide;

  logic        valid_r;
  logic        echo_valid_r, echo_valid_nxt;
  logic [7:0]  echo_char_r, echo_char_nxt;
  logic        extra_nl_r, extra_nl_nxt;
  logic        store_valid_r, store_valid_nxt;
  logic [7:0]  store_char_r, store_char_nxt;
  logic [15:0] store_index_r, store_index_nxt;
  logic        done_valid_r, done_valid_nxt;
  logic [15:0] done_count_r, done_count_nxt;
  logic        ack_r, ack_nxt;
  logic [1:0]  scroll_r, scroll_nxt;
  logic        console_valid_r, console_valid_nxt;
  logic [3:0]  console_index_r, console_index_nxt;
  logic        printable;

  assign pop = !status.empty && (!valid_r || out_ready);

  assign req_wide      = {{COUNT_WIDTH{1'b0}}, head_cmd.req};
  assign xfer_wide     = {16'b0, xfer_r};
  assign xfer_nxt_wide = {16'b0, xfer_nxt};
  assign printable     = (head_cmd.ch >= tcli_pkg::CH_SPACE) &&
                         (head_cmd.ch <= tcli_pkg::CH_TILDE);

  always_comb begin
    rem_nxt           = rem_r;
    xfer_nxt          = xfer_r;
    echo_valid_nxt    = 1'b0;
    echo_char_nxt     = '0;
    extra_nl_nxt      = 1'b0;
    store_valid_nxt   = 1'b0;
    store_char_nxt    = '0;
    store_index_nxt   = '0;
    done_valid_nxt    = 1'b0;
    done_count_nxt    = '0;
    ack_nxt           = 1'b0;
    scroll_nxt        = tcli_pkg::SCROLL_NONE;
    console_valid_nxt = 1'b0;
    console_index_nxt = '0;
    unique case (head_cmd.kind)
      tcli_pkg::CMD_REQUEST: begin
        rem_nxt  = req_wide[COUNT_WIDTH-1:0];
        xfer_nxt = '0;
        ack_nxt  = 1'b1;
      end
      tcli_pkg::CMD_CHAR: begin
        if (rem_r != '0) begin
          if (printable) begin
            echo_valid_nxt  = 1'b1;
            echo_char_nxt   = head_cmd.ch;
            store_valid_nxt = 1'b1;
            store_char_nxt  = head_cmd.ch;
            store_index_nxt = xfer_wide[15:0];
            xfer_nxt        = xfer_r + 1'b1;
            rem_nxt         = rem_r - 1'b1;
          end else if (head_cmd.ch == tcli_pkg::CH_BACKSPACE && xfer_r != '0) begin
            echo_valid_nxt = 1'b1;
            echo_char_nxt  = head_cmd.ch;
            xfer_nxt       = xfer_r - 1'b1;
            rem_nxt        = rem_r + 1'b1;
          end
          if (head_cmd.ch == tcli_pkg::CH_NEWLINE || rem_nxt == '0) begin
            extra_nl_nxt   = 1'b1;
            done_valid_nxt = 1'b1;
            done_count_nxt = xfer_nxt_wide[15:0];
            rem_nxt        = '0;
          end
        end
      end
      tcli_pkg::CMD_SCROLL: begin
        scroll_nxt = head_cmd.scroll;
      end
      tcli_pkg::CMD_CONSOLE: begin
        console_valid_nxt = 1'b1;
        console_index_nxt = head_cmd.console;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      xfer_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (pop) begin
        rem_r   <= rem_nxt;
        xfer_r  <= xfer_nxt;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      echo_valid_r    <= echo_valid_nxt;
      echo_char_r     <= echo_char_nxt;
      extra_nl_r      <= extra_nl_nxt;
      store_valid_r   <= store_valid_nxt;
      store_char_r    <= store_char_nxt;
      store_index_r   <= store_index_nxt;
      done_valid_r    <= done_valid_nxt;
      done_count_r    <= done_count_nxt;
      ack_r           <= ack_nxt;
      scroll_r        <= scroll_nxt;
      console_valid_r <= console_valid_nxt;
      console_index_r <= console_index_nxt;
    end
  end

  assign out_valid                = valid_r;
  assign out_echo_valid           = echo_valid_r;
  assign out_echo_char            = echo_char_r;
  assign out_extra_newline        = extra_nl_r;
  assign out_store_valid          = store_valid_r;
  assign out_store_char           = store_char_r;
  assign out_store_index          = store_index_r;
  assign out_done_valid           = done_valid_r;
  assign out_done_count           = done_count_r;
  assign out_request_ack          = ack_r;
  assign out_scroll_dir           = scroll_r;
  assign out_console_select_valid = console_valid_r;
  assign out_console_index        = console_index_r;

  a_store_echoes : assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && store_valid_r) |-> echo_valid_r)
    else $error("stored character was not echoed");

  a_request_acked : assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_cmd.kind == tcli_pkg::CMD_REQUEST) |=> (ack_r && xfer_r == '0))
    else $error("read request not acknowledged with cleared count");

  a_done_closes : assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (!done_valid_r || rem_r == '0))
    else $error("request completed but still open");

  a_done_newline : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (done_valid_r == extra_nl_r))
    else $error("completion without newline echo");

endmodule

/* hw/rtl/tty_canonical_line_input.sv */
// Canonical-mode terminal line input.
// The input channel (in_valid/in_ready) carries one beat per key event or
// read request. A read request opens a line of in_request_count characters
// and is answered by a beat with request_ack set. Key beats are decoded into
// echo, store, completion, scroll and console-select actions.
// The output channel (out_valid/out_ready) returns exactly one beat for every
// accepted input beat, in order.
// An accepted beat is written into the command queue; out_valid rises once
// the execute stage pops it into the output register. While out_ready is high
// the block takes one beat per cycle: a classify stage feeds a two-entry queue
// that the execute stage drains one command per cycle, updating its counts.
// When the receiver stalls, the result holds in the output register and the
// queue takes up to two more beats before in_ready falls.
// Reset clears the queue, the output valid flag and both line counts, so no
// request is open after reset.
module tty_canonical_line_input #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_key_char,
  input  logic        in_is_extended,
  input  logic [2:0]  in_ext_key,
  input  logic [3:0]  in_function_index,
  input  logic        in_shift_held,
  input  logic [15:0] in_request_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_echo_valid,
  output logic [7:0]  out_echo_char,
  output logic        out_extra_newline,
  output logic        out_store_valid,
  output logic [7:0]  out_store_char,
  output logic [15:0] out_store_index,
  output logic        out_done_valid,
  output logic [15:0] out_done_count,
  output logic        out_request_ack,
  output logic [1:0]  out_scroll_dir,
  output logic        out_console_select_valid,
  output logic [3:0]  out_console_index
);

  logic                    push;
  logic                    pop;
  tcli_pkg::cmd_t          push_cmd;
  tcli_pkg::cmd_t          head_cmd;
  tcli_pkg::queue_status_t status;

  tcli_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_key_char       (in_key_char),
    .in_is_extended    (in_is_extended),
    .in_ext_key        (in_ext_key),
    .in_function_index (in_function_index),
    .in_shift_held     (in_shift_held),
    .in_request_count  (in_request_count),
    .queue_full        (status.full),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  tcli_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (status)
  );

  tcli_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .head_cmd                 (head_cmd),
    .status                   (status),
    .pop                      (pop),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_echo_valid           (out_echo_valid),
    .out_echo_char            (out_echo_char),
    .out_extra_newline        (out_extra_newline),
    .out_store_valid          (out_store_valid),
    .out_store_char           (out_store_char),
    .out_store_index          (out_store_index),
    .out_done_valid           (out_done_valid),
    .out_done_count           (out_done_count),
    .out_request_ack          (out_request_ack),
    .out_scroll_dir           (out_scroll_dir),
    .out_console_select_valid (out_console_select_valid),
    .out_console_index        (out_console_index)
  );

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] EXT_OTHER    = 3'd0;
  localparam logic [2:0] EXT_RESERVED = 3'd7;
  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_START   = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int PRINT_LIMIT  = 50;

  typedef struct packed {
    logic        op;
    logic [7:0]  key;
    logic        ext;
    logic [2:0]  code;
    logic [3:0]  fidx;
    logic        shift;
    logic [15:0] count;
  } tty_input_t;

  typedef struct packed {
    logic        echo_v;
    logic [7:0]  echo_ch;
    logic        newline;
    logic        store_v;
    logic [7:0]  store_ch;
    logic [15:0] store_idx;
    logic        done_v;
    logic [15:0] done_cnt;
    logic        ack;
    logic [1:0]  scroll;
    logic        sel_v;
    logic [3:0]  console;
  } line_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = tcli_pkg::OP_KEY;
  logic [7:0]  in_key_char = 8'h00;
  logic        in_is_extended = 1'b0;
  logic [2:0]  in_ext_key = EXT_OTHER;
  logic [3:0]  in_function_index = 4'd0;
  logic        in_shift_held = 1'b0;
  logic [15:0] in_request_count = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_echo_valid;
  logic [7:0]  out_echo_char;
  logic        out_extra_newline;
  logic        out_store_valid;
  logic [7:0]  out_store_char;
  logic [15:0] out_store_index;
  logic        out_done_valid;
  logic [15:0] out_done_count;
  logic        out_request_ack;
  logic [1:0]  out_scroll_dir;
  logic        out_console_select_valid;
  logic [3:0]  out_console_index;

  tty_input_t   pending_keys[$];
  line_result_t expected_lines[$];
  tty_input_t   offered;

  logic [15:0] open_left = 16'd0;
  logic [15:0] typed_count = 16'd0;

  int errors = 0;
  int beats_sent = 0;
  int beats_seen = 0;
  int lines_done = 0;
  int chars_stored = 0;
  int screen_actions = 0;
  int cycles_run = 0;
  int in_gap = 0;
  int in_calm = 0;
  int out_stall = 0;
  int out_calm = 0;
  int rx_cycles = 0;
  int hold_left = 0;

  tty_canonical_line_input u_top (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_operation             (in_operation),
    .in_key_char              (in_key_char),
    .in_is_extended           (in_is_extended),
    .in_ext_key               (in_ext_key),
    .in_function_index        (in_function_index),
    .in_shift_held            (in_shift_held),
    .in_request_count         (in_request_count),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_echo_valid           (out_echo_valid),
    .out_echo_char            (out_echo_char),
    .out_extra_newline        (out_extra_newline),
    .out_store_valid          (out_store_valid),
    .out_store_char           (out_store_char),
    .out_store_index          (out_store_index),
    .out_done_valid           (out_done_valid),
    .out_done_count           (out_done_count),
    .out_request_ack          (out_request_ack),
    .out_scroll_dir           (out_scroll_dir),
    .out_console_select_valid (out_console_select_valid),
    .out_console_index        (out_console_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tty_input_t any_input();
    tty_input_t it;
    it.op    = 1'($urandom_range(0, 1));
    it.key   = 8'($urandom_range(0, 255));
    it.ext   = 1'($urandom_range(0, 1));
    it.code  = 3'($urandom_range(0, 7));
    it.fidx  = 4'($urandom_range(0, 15));
    it.shift = 1'($urandom_range(0, 1));
    it.count = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic tty_input_t make_request(logic [15:0] count);
    tty_input_t it;
    it = any_input();
    it.op = tcli_pkg::OP_REQUEST;
    it.count = count;
    return it;
  endfunction

  function automatic tty_input_t make_key(logic [7:0] ch);
    tty_input_t it;
    it = any_input();
    it.op = tcli_pkg::OP_KEY;
    it.ext = 1'b0;
    it.key = ch;
    return it;
  endfunction

  function automatic tty_input_t make_ext(logic [2:0] code, logic shift, logic [3:0] fidx);
    tty_input_t it;
    it = any_input();
    it.op = tcli_pkg::OP_KEY;
    it.ext = 1'b1;
    it.code = code;
    it.shift = shift;
    it.fidx = fidx;
    return it;
  endfunction

  function automatic line_result_t predict_line(tty_input_t it);
    line_result_t r;
    logic         feed;
    logic [7:0]   ch;
    r = '0;
    feed = 1'b0;
    ch = it.key;
    if (it.op == tcli_pkg::OP_REQUEST) begin
      open_left = it.count;
      typed_count = '0;
      r.ack = 1'b1;
      return r;
    end
    if (!it.ext) begin
      feed = 1'b1;
    end else begin
      case (it.code)
        tcli_pkg::EXT_ENTER: begin
          feed = 1'b1;
          ch = tcli_pkg::CH_NEWLINE;
        end
        tcli_pkg::EXT_BACKSPACE: begin
          feed = 1'b1;
          ch = tcli_pkg::CH_BACKSPACE;
        end
        tcli_pkg::EXT_UP: begin
          if (it.shift) r.scroll = tcli_pkg::SCROLL_UP;
        end
        tcli_pkg::EXT_DOWN: begin
          if (it.shift) r.scroll = tcli_pkg::SCROLL_DOWN;
        end
        tcli_pkg::EXT_FUNCTION: begin
          if (it.shift && it.fidx <= tcli_pkg::LAST_CONSOLE) begin
            r.sel_v = 1'b1;
            r.console = it.fidx;
          end
        end
        default: ;
      endcase
    end
    if (feed && open_left != 0) begin
      if (ch >= tcli_pkg::CH_SPACE && ch <= tcli_pkg::CH_TILDE) begin
        r.echo_v = 1'b1;
        r.echo_ch = ch;
        r.store_v = 1'b1;
        r.store_ch = ch;
        r.store_idx = typed_count;
        typed_count = typed_count + 1'b1;
        open_left = open_left - 1'b1;
      end else if (ch == tcli_pkg::CH_BACKSPACE && typed_count != 0) begin
        r.echo_v = 1'b1;
        r.echo_ch = ch;
        typed_count = typed_count - 1'b1;
        open_left = open_left + 1'b1;
      end
      if (ch == tcli_pkg::CH_NEWLINE || open_left == 0) begin
        r.newline = 1'b1;
        r.done_v = 1'b1;
        r.done_cnt = typed_count;
        open_left = '0;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < PRINT_LIMIT) $display("mismatch at beat %0d: %s", beats_seen, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_lines.push_back(predict_line(offered));
        beats_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_keys.size() > 0) begin
          offered = pending_keys.pop_front();
          in_valid <= 1'b1;
          in_operation <= offered.op;
          in_key_char <= offered.key;
          in_is_extended <= offered.ext;
          in_ext_key <= offered.code;
          in_function_index <= offered.fidx;
          in_shift_held <= offered.shift;
          in_request_count <= offered.count;
          if (in_calm > 0) begin
            in_calm--;
          end else begin
            in_gap = pick_gap();
            if ($urandom_range(0, 49) == 0) in_calm = $urandom_range(30, 80);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The long hold-off lets the command queue fill so that in_ready falls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_calm > 0) begin
          out_calm--;
        end else begin
          if ($urandom_range(0, 2) == 0) out_stall = pick_gap();
          if ($urandom_range(0, 49) == 0) out_calm = $urandom_range(30, 80);
        end
      end
    end
  end

  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (expected_lines.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        want = expected_lines.pop_front();
        check_field("echo_valid", 32'(out_echo_valid), 32'(want.echo_v));
        check_field("echo_char", 32'(out_echo_char), 32'(want.echo_ch));
        check_field("extra_newline", 32'(out_extra_newline), 32'(want.newline));
        check_field("store_valid", 32'(out_store_valid), 32'(want.store_v));
        check_field("store_char", 32'(out_store_char), 32'(want.store_ch));
        check_field("store_index", 32'(out_store_index), 32'(want.store_idx));
        check_field("done_valid", 32'(out_done_valid), 32'(want.done_v));
        check_field("done_count", 32'(out_done_count), 32'(want.done_cnt));
        check_field("request_ack", 32'(out_request_ack), 32'(want.ack));
        check_field("scroll_dir", 32'(out_scroll_dir), 32'(want.scroll));
        check_field("console_select_valid", 32'(out_console_select_valid),
                    32'(want.sel_v));
        check_field("console_index", 32'(out_console_index), 32'(want.console));
        if (want.done_v) lines_done++;
        if (want.store_v) chars_stored++;
        if (want.scroll != tcli_pkg::SCROLL_NONE || want.sel_v) screen_actions++;
      end
    end
  end

  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles_run);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int          queued;
    int          len;
    int          r;
    logic [15:0] count;

    pending_keys.push_back(make_key("a"));
    pending_keys.push_back(make_ext(tcli_pkg::EXT_UP, 1'b1, 4'd0));
    pending_keys.push_back(make_ext(tcli_pkg::EXT_DOWN, 1'b1, 4'd0));
    pending_keys.push_back(make_ext(tcli_pkg::EXT_UP, 1'b0, 4'd0));
    pending_keys.push_back(make_ext(tcli_pkg::EXT_FUNCTION, 1'b1, 4'd0));
    pending_keys.push_back(make_ext(tcli_pkg::EXT_FUNCTION, 1'b1, tcli_pkg::LAST_CONSOLE));
    pending_keys.push_back(make_ext(tcli_pkg::EXT_FUNCTION, 1'b1, 4'd15));
    pending_keys.push_back(make_ext(tcli_pkg::EXT_FUNCTION, 1'b0, 4'd4));
    pending_keys.push_back(make_ext(EXT_OTHER, 1'b1, 4'd0));
    pending_keys.push_back(make_ext(EXT_RESERVED, 1'b1, 4'd0));
    pending_keys.push_back(make_request(16'd0));
    pending_keys.push_back(make_key("x"));
    pending_keys.push_back(make_request(16'd3));
    pending_keys.push_back(make_ext(tcli_pkg::EXT_BACKSPACE, 1'b0, 4'd0));
    pending_keys.push_back(make_key(tcli_pkg::CH_SPACE));
    pending_keys.push_back(make_key(tcli_pkg::CH_TILDE));
    pending_keys.push_back(make_key(tcli_pkg::CH_BACKSPACE));
    pending_keys.push_back(make_key(8'h7F));
    pending_keys.push_back(make_key(8'hFF));
    pending_keys.push_back(make_key("z"));
    pending_keys.push_back(make_key("!"));
    pending_keys.push_back(make_request(16'hFFFF));
    pending_keys.push_back(make_key("A"));
    pending_keys.push_back(make_key(tcli_pkg::CH_NEWLINE));
    pending_keys.push_back(make_request(16'd4));
    pending_keys.push_back(make_request(16'd1));
    pending_keys.push_back(make_key(8'h1F));
    pending_keys.push_back(make_key("k"));
    pending_keys.push_back(make_request(16'd5));
    pending_keys.push_back(make_ext(tcli_pkg::EXT_ENTER, 1'b0, 4'd0));

    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 19);
        if (r == 0) count = 16'($urandom_range(0, 65535));
        else if (r == 1) count = 16'd0;
        else count = 16'($urandom_range(1, 12));
        pending_keys.push_back(make_request(count));
        queued++;
        len = (count > 16) ? $urandom_range(5, 20) : count + $urandom_range(0, 3);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 65) begin
            pending_keys.push_back(make_key(8'($urandom_range(tcli_pkg::CH_SPACE,
                                                              tcli_pkg::CH_TILDE))));
          end else if (r < 77) begin
            if (r[0]) pending_keys.push_back(make_key(tcli_pkg::CH_BACKSPACE));
            else pending_keys.push_back(make_ext(tcli_pkg::EXT_BACKSPACE,
                                                 1'($urandom_range(0, 1)), 4'd0));
          end else if (r < 82) begin
            if (r[0]) pending_keys.push_back(make_key(tcli_pkg::CH_NEWLINE));
            else pending_keys.push_back(make_ext(tcli_pkg::EXT_ENTER,
                                                 1'($urandom_range(0, 1)), 4'd0));
          end else if (r < 90) begin
            pending_keys.push_back(make_ext(3'($urandom_range(tcli_pkg::EXT_UP,
                                                              tcli_pkg::EXT_FUNCTION)),
                                            1'($urandom_range(0, 1)),
                                            4'($urandom_range(0, 15))));
          end else begin
            pending_keys.push_back(make_key(8'($urandom_range(0, 255))));
          end
          queued++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          pending_keys.push_back(any_input());
          queued++;
        end
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_keys.size() != 0 || in_valid || expected_lines.size() != 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d beats and checked %0d results with random stalls on both sides.",
             beats_sent, beats_seen);
    $display("Lines completed: %0d, characters stored: %0d, scroll or console actions: %0d.",
             lines_done, chars_stored, screen_actions);
    if (errors == 0 && expected_lines.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
